// ----- hw/rtl/ihex_pkg.sv -----
package ihex_pkg;

	// Page geometry: PAGE_BYTES must be a power of two
	localparam int unsigned PAGE_BYTES = 2048;
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

	// Field widths
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned PAGE_NUM_W = 21;
	localparam int unsigned PAGE_OFF_W = 11;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ERR_W = 3;

	// Depth of the queue between parser and result stage
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Characters of interest
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;

	// Record types
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF = 8'h01;
	localparam logic [7:0] REC_SEG = 8'h02;
	localparam logic [7:0] REC_LIN = 8'h04;
	localparam logic [7:0] REC_START = 8'h05;

	localparam logic [7:0] BASE_REC_LEN = 8'd2;
	localparam logic [7:0] EXT_BYTES = 8'd2;
	localparam logic [7:0] START_BYTES = 8'd4;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EOF   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_INVALID   = 3'd1,
		ERR_CHECKSUM  = 3'd2,
		ERR_TYPE      = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		PH_WAIT    = 4'd0,
		PH_LEN     = 4'd1,
		PH_ADDR_HI = 4'd2,
		PH_ADDR_LO = 4'd3,
		PH_TYPE    = 4'd4,
		PH_DATA    = 4'd5,
		PH_EXT     = 4'd6,
		PH_START   = 4'd7,
		PH_CSUM    = 4'd8
	} phase_t;

	// Everything one character produces: an optional data byte, then an
	// optional terminating result (end of file or error)
	typedef struct packed {
		logic              has_data;
		logic              has_term;
		logic              term_eof;
		err_t              err;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] value;
	} bundle_t;

	// Hex digit decode: bit 4 is the valid flag
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ----- hw/rtl/ihex_front.sv -----
module ihex_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [ihex_pkg::CHAR_W-1:0]    char_code,
	input  logic                           end_of_text,
	output logic                           bundle_push,
	output ihex_pkg::bundle_t              bundle
);
	import ihex_pkg::*;

	phase_t        phase_q, phase_d;
	logic [3:0]    high_nibble_q, high_nibble_d;
	logic          nibble_pending_q, nibble_pending_d;
	logic [7:0]    record_length_q, record_length_d;
	logic [15:0]   record_offset_q, record_offset_d;
	logic [7:0]    record_kind_q, record_kind_d;
	logic [7:0]    running_sum_q, running_sum_d;
	logic [31:0]   base_address_q, base_address_d;
	logic [7:0]    bytes_seen_q, bytes_seen_d;
	logic [15:0]   upper_word_q, upper_word_d;
	logic          finished_q, finished_d;

	logic [4:0]    digit;
	logic [7:0]    b;
	logic [7:0]    seen_inc;
	logic [31:0]   data_addr;

	assign digit = hex_digit(char_code);
	assign b = {high_nibble_q, digit[3:0]};
	assign seen_inc = bytes_seen_q + 8'd1;
	assign data_addr = base_address_q + {16'd0, record_offset_q} + {24'd0, bytes_seen_q};

	// Parser next state and the results of this character
	always_comb begin
		phase_d = phase_q;
		high_nibble_d = high_nibble_q;
		nibble_pending_d = nibble_pending_q;
		record_length_d = record_length_q;
		record_offset_d = record_offset_q;
		record_kind_d = record_kind_q;
		running_sum_d = running_sum_q;
		base_address_d = base_address_q;
		bytes_seen_d = bytes_seen_q;
		upper_word_d = upper_word_q;
		finished_d = finished_q;
		bundle = '0;
		bundle.err = ERR_NONE;

		if (!finished_q) begin
			if (phase_q == PH_WAIT || phase_q > PH_CSUM) begin
				if (char_code == CH_COLON) begin
					phase_d = PH_LEN;
					running_sum_d = '0;
					nibble_pending_d = 1'b0;
				end else if (!is_space(char_code)) begin
					bundle.has_term = 1'b1;
					bundle.err = ERR_INVALID;
					finished_d = 1'b1;
				end
			end else if (!digit[4]) begin
				bundle.has_term = 1'b1;
				bundle.err = ERR_INVALID;
				finished_d = 1'b1;
			end else if (!nibble_pending_q) begin
				high_nibble_d = digit[3:0];
				nibble_pending_d = 1'b1;
			end else begin
				// a whole byte is complete
				nibble_pending_d = 1'b0;
				if (phase_q != PH_CSUM) begin
					running_sum_d = running_sum_q + b;
				end
				unique case (phase_q)
					PH_LEN: begin
						record_length_d = b;
						phase_d = PH_ADDR_HI;
					end
					PH_ADDR_HI: begin
						record_offset_d = {b, 8'd0};
						phase_d = PH_ADDR_LO;
					end
					PH_ADDR_LO: begin
						record_offset_d = {record_offset_q[15:8], b};
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						record_kind_d = b;
						bytes_seen_d = '0;
						if (b == REC_DATA) begin
							phase_d = (record_length_q != 8'd0) ? PH_DATA : PH_CSUM;
						end else if (b == REC_EOF) begin
							bundle.has_term = 1'b1;
							bundle.term_eof = 1'b1;
							finished_d = 1'b1;
						end else if (b == REC_SEG || b == REC_LIN) begin
							if (record_length_q != BASE_REC_LEN) begin
								bundle.has_term = 1'b1;
								bundle.err = ERR_INVALID;
								finished_d = 1'b1;
							end else begin
								phase_d = PH_EXT;
							end
						end else if (b == REC_START) begin
							phase_d = PH_START;
						end else begin
							bundle.has_term = 1'b1;
							bundle.err = ERR_TYPE;
							finished_d = 1'b1;
						end
					end
					PH_DATA: begin
						bundle.has_data = 1'b1;
						bundle.addr = data_addr;
						bundle.value = b;
						bytes_seen_d = seen_inc;
						if (seen_inc == record_length_q) begin
							phase_d = PH_CSUM;
						end
					end
					PH_EXT: begin
						upper_word_d = {upper_word_q[7:0], b};
						bytes_seen_d = seen_inc;
						if (seen_inc >= EXT_BYTES) begin
							phase_d = PH_CSUM;
						end
					end
					PH_START: begin
						bytes_seen_d = seen_inc;
						if (seen_inc >= START_BYTES) begin
							phase_d = PH_CSUM;
						end
					end
					default: begin
						// checksum byte
						if (b != 8'(8'd0 - running_sum_q)) begin
							bundle.has_term = 1'b1;
							bundle.err = ERR_CHECKSUM;
							finished_d = 1'b1;
						end else begin
							if (record_kind_q == REC_SEG) begin
								base_address_d = {12'd0, upper_word_q, 4'd0};
							end else if (record_kind_q == REC_LIN) begin
								base_address_d = {upper_word_q, 16'd0};
							end
							phase_d = PH_WAIT;
						end
					end
				endcase
			end

			// text ran out before the end of file record
			if (end_of_text && !finished_d) begin
				bundle.has_term = 1'b1;
				bundle.term_eof = 1'b0;
				bundle.err = ERR_TRUNCATED;
				finished_d = 1'b1;
			end
		end
	end

	assign bundle_push = accept && (bundle.has_data || bundle.has_term);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			high_nibble_q <= '0;
			nibble_pending_q <= 1'b0;
			record_length_q <= '0;
			record_offset_q <= '0;
			record_kind_q <= '0;
			running_sum_q <= '0;
			base_address_q <= '0;
			bytes_seen_q <= '0;
			upper_word_q <= '0;
			finished_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			high_nibble_q <= high_nibble_d;
			nibble_pending_q <= nibble_pending_d;
			record_length_q <= record_length_d;
			record_offset_q <= record_offset_d;
			record_kind_q <= record_kind_d;
			running_sum_q <= running_sum_d;
			base_address_q <= base_address_d;
			bytes_seen_q <= bytes_seen_d;
			upper_word_q <= upper_word_d;
			finished_q <= finished_d;
		end
	end

endmodule

// ----- hw/rtl/ihex_queue.sv -----
module ihex_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ihex_pkg::bundle_t push_data,
	output logic              full,
	input  logic              pop,
	output ihex_pkg::bundle_t head,
	output logic              empty
);
	import ihex_pkg::*;

	bundle_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/ihex_back.sv -----
module ihex_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ihex_pkg::bundle_t                 head,
	input  logic                              head_empty,
	input  logic                              pop,
	output logic                              head_pop,
	output logic [ihex_pkg::KIND_W-1:0]       kind,
	output logic [ihex_pkg::ADDR_W-1:0]       byte_address,
	output logic [ihex_pkg::PAGE_NUM_W-1:0]   page_number,
	output logic [ihex_pkg::PAGE_OFF_W-1:0]   page_offset,
	output logic [ihex_pkg::BYTE_W-1:0]       byte_value,
	output logic [ihex_pkg::ERR_W-1:0]        error_code,
	output logic                              last_of_run
);
	import ihex_pkg::*;

	logic sel_q;
	logic two_results;
	logic show_term;
	logic take;

	assign two_results = head.has_data && head.has_term;
	assign show_term = sel_q || !head.has_data;
	assign take = pop && !head_empty;
	assign head_pop = take && (sel_q || !two_results);

	// Result fields for the item at the head of the queue
	always_comb begin
		kind = KIND_DATA;
		byte_address = '0;
		page_number = '0;
		page_offset = '0;
		byte_value = '0;
		error_code = ERR_NONE;
		if (show_term) begin
			if (head.term_eof) begin
				kind = KIND_EOF;
			end else begin
				kind = KIND_ERROR;
				error_code = head.err;
			end
		end else begin
			byte_address = head.addr;
			page_number = PAGE_NUM_W'(head.addr >> PAGE_SHIFT);
			page_offset = PAGE_OFF_W'(head.addr & PAGE_MASK);
			byte_value = head.value;
		end
		last_of_run = !(two_results && !sel_q);
	end

	// Which of the two results of a bundle is on show
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= two_results && !sel_q;
		end
	end

endmodule

// ----- hw/rtl/intel_hex_record_parser_unit.sv -----
// Intel HEX record parser.
// Input channel: one character of hex text per item on char_code, with
// end_of_text set on the final character. An item is taken when push is
// high and full is low. Result channel: while empty is low the oldest
// result is on kind, byte_address, page_number, page_offset, byte_value,
// error_code and last_of_run; it is taken when pop is high.
// A character is parsed in the cycle it is taken; its results (none, one
// or two) are registered in the queue and reach the result ports once all
// older results are popped. The block takes one character every cycle
// while full is low; a character that yields two results (a data byte
// followed by a truncation error) needs two pops at the output. Results
// wait in a four-entry queue between the parser and the output stage;
// when the receiver stalls, full rises once the queue holds four
// characters' results and input stalls with it.
// Data bytes leave before their record checksum is seen, so a consumer
// drops the bytes of a record that is followed by an error. After an end
// of file or error result, further characters are taken and ignored.
// Reset clears the parser to wait for a colon with base address zero and empties the queue.
module intel_hex_record_parser_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [ihex_pkg::CHAR_W-1:0]       char_code,
	input  logic                              end_of_text,
	output logic                              empty,
	input  logic                              pop,
	output logic [ihex_pkg::KIND_W-1:0]       kind,
	output logic [ihex_pkg::ADDR_W-1:0]       byte_address,
	output logic [ihex_pkg::PAGE_NUM_W-1:0]   page_number,
	output logic [ihex_pkg::PAGE_OFF_W-1:0]   page_offset,
	output logic [ihex_pkg::BYTE_W-1:0]       byte_value,
	output logic [ihex_pkg::ERR_W-1:0]        error_code,
	output logic                              last_of_run
);
	import ihex_pkg::*;

	logic    accept;
	logic    bundle_push;
	bundle_t bundle;
	bundle_t head;
	logic    head_pop;

	assign accept = push && !full;

	// Parser
	ihex_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.bundle_push (bundle_push),
		.bundle      (bundle)
	);

	// Decoupling queue
	ihex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (bundle_push),
		.push_data (bundle),
		.full      (full),
		.pop       (head_pop),
		.head      (head),
		.empty     (empty)
	);

	// Result stage
	ihex_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_empty   (empty),
		.pop          (pop),
		.head_pop     (head_pop),
		.kind         (kind),
		.byte_address (byte_address),
		.page_number  (page_number),
		.page_offset  (page_offset),
		.byte_value   (byte_value),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- bench/ihex_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the parser, predicts the results of every accepted
// character and compares each popped result with the oldest prediction.
module ihex_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic [ihex_pkg::CHAR_W-1:0]       char_code,
	input  logic                              end_of_text,
	input  logic                              empty,
	input  logic                              pop,
	input  logic [ihex_pkg::KIND_W-1:0]       kind,
	input  logic [ihex_pkg::ADDR_W-1:0]       byte_address,
	input  logic [ihex_pkg::PAGE_NUM_W-1:0]   page_number,
	input  logic [ihex_pkg::PAGE_OFF_W-1:0]   page_offset,
	input  logic [ihex_pkg::BYTE_W-1:0]       byte_value,
	input  logic [ihex_pkg::ERR_W-1:0]        error_code,
	input  logic                              last_of_run,
	output int                                mismatches,
	output int                                outstanding
);
	import ihex_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic [ADDR_W-1:0]     addr;
		logic [PAGE_NUM_W-1:0] page;
		logic [PAGE_OFF_W-1:0] offset;
		logic [BYTE_W-1:0]     value;
		err_t                  err;
		logic                  last;
	} parsed_t;

	// Parser state as the checker tracks it
	phase_t      ph;
	logic [3:0]  hi_nib;
	logic        nib_pend;
	logic [7:0]  rec_len;
	logic [15:0] rec_off;
	logic [7:0]  rec_type;
	logic [7:0]  sum;
	logic [31:0] base;
	logic [7:0]  nbytes;
	logic [15:0] ext_word;
	logic        done;

	parsed_t awaited_q[$];
	parsed_t char_out[$];
	parsed_t seen;
	parsed_t want;

	function automatic bit is_hex_char(input logic [7:0] c);
		return c inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]};
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c inside {[CH_0:CH_9]}) begin
			return 4'(c - CH_0);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			return 4'(c - CH_UA) + 4'd10;
		end
		return 4'(c - CH_LA) + 4'd10;
	endfunction

	function automatic void add_result(input kind_t k, input logic [31:0] a,
			input logic [7:0] v, input err_t e);
		parsed_t r;
		r = '0;
		r.kind = k;
		r.err = e;
		// address, page and byte only carry meaning on data results
		if (k == KIND_DATA) begin
			r.addr = a;
			r.page = PAGE_NUM_W'(a / PAGE_BYTES);
			r.offset = PAGE_OFF_W'(a % PAGE_BYTES);
			r.value = v;
		end
		char_out.insert(char_out.size(), r);
	endfunction

	function automatic void abort(input err_t e);
		add_result(KIND_ERROR, '0, '0, e);
		done = 1'b1;
	endfunction

	// One complete byte of a record
	function automatic void take_byte(input logic [7:0] b);
		if (ph != PH_CSUM) sum = 8'(sum + b);
		case (ph)
			PH_LEN: begin
				rec_len = b;
				ph = PH_ADDR_HI;
			end
			PH_ADDR_HI: begin
				rec_off = {b, 8'h00};
				ph = PH_ADDR_LO;
			end
			PH_ADDR_LO: begin
				rec_off[7:0] = b;
				ph = PH_TYPE;
			end
			PH_TYPE: begin
				rec_type = b;
				nbytes = '0;
				if (b == REC_DATA) begin
					ph = (rec_len != 8'd0) ? PH_DATA : PH_CSUM;
				end else if (b == REC_EOF) begin
					add_result(KIND_EOF, '0, '0, ERR_NONE);
					done = 1'b1;
				end else if (b == REC_SEG || b == REC_LIN) begin
					if (rec_len != BASE_REC_LEN) abort(ERR_INVALID);
					else ph = PH_EXT;
				end else if (b == REC_START) begin
					ph = PH_START;
				end else begin
					abort(ERR_TYPE);
				end
			end
			PH_DATA: begin
				add_result(KIND_DATA, base + 32'(rec_off) + 32'(nbytes), b, ERR_NONE);
				nbytes = 8'(nbytes + 1);
				if (nbytes == rec_len) ph = PH_CSUM;
			end
			PH_EXT: begin
				ext_word = {ext_word[7:0], b};
				nbytes = 8'(nbytes + 1);
				if (nbytes >= EXT_BYTES) ph = PH_CSUM;
			end
			PH_START: begin
				nbytes = 8'(nbytes + 1);
				if (nbytes >= START_BYTES) ph = PH_CSUM;
			end
			default: begin
				// base only moves once the checksum agrees
				if (8'(b + sum) != 8'h00) begin
					abort(ERR_CHECKSUM);
				end else begin
					if (rec_type == REC_SEG) base = {12'h000, ext_word, 4'h0};
					else if (rec_type == REC_LIN) base = {ext_word, 16'h0000};
					ph = PH_WAIT;
				end
			end
		endcase
	endfunction

	// Results of one accepted character, appended to the awaited results
	function automatic void parse_char(input logic [7:0] c, input logic eot);
		char_out.delete();
		if (done) return;
		if (ph == PH_WAIT || ph > PH_CSUM) begin
			if (c == CH_COLON) begin
				ph = PH_LEN;
				sum = '0;
				nib_pend = 1'b0;
			end else if (!(c inside {CH_SPACE, [CH_TAB:CH_CR]})) begin
				abort(ERR_INVALID);
			end
		end else if (!is_hex_char(c)) begin
			abort(ERR_INVALID);
		end else if (!nib_pend) begin
			hi_nib = nibble_of(c);
			nib_pend = 1'b1;
		end else begin
			nib_pend = 1'b0;
			take_byte({hi_nib, nibble_of(c)});
		end
		// text ran out before the parse finished
		if (eot && !done) abort(ERR_TRUNCATED);
		if (char_out.size() > 0) char_out[char_out.size() - 1].last = 1'b1;
		foreach (char_out[i]) awaited_q.insert(awaited_q.size(), char_out[i]);
	endfunction

	function automatic void note_mismatch(input string what, input parsed_t exp_r,
			input parsed_t got_r);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: exp kind %0d addr %h page %h off %h byte %h err %0d last %b",
				$time, what, exp_r.kind, exp_r.addr, exp_r.page, exp_r.offset,
				exp_r.value, exp_r.err, exp_r.last);
			$display("%0t %s: got kind %0d addr %h page %h off %h byte %h err %0d last %b",
				$time, what, got_r.kind, got_r.addr, got_r.page, got_r.offset,
				got_r.value, got_r.err, got_r.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_WAIT;
			hi_nib = '0;
			nib_pend = 1'b0;
			rec_len = '0;
			rec_off = '0;
			rec_type = '0;
			sum = '0;
			base = '0;
			nbytes = '0;
			ext_word = '0;
			done = 1'b0;
			awaited_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// predict from the character taken at this edge
			if (push && !full) parse_char(char_code, end_of_text);
			// compare the result taken at this edge
			if (pop && !empty) begin
				seen.kind = kind_t'(kind);
				seen.addr = byte_address;
				seen.page = page_number;
				seen.offset = page_offset;
				seen.value = byte_value;
				seen.err = err_t'(error_code);
				seen.last = last_of_run;
				if (awaited_q.size() == 0) begin
					note_mismatch("result with none expected", '0, seen);
				end else begin
					want = awaited_q.pop_front();
					if (seen !== want) note_mismatch("wrong result", want, seen);
				end
			end
			outstanding = awaited_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import ihex_pkg::*;

	localparam int CYCLE_LIMIT = 50000;
	localparam int HOLD_CYCLES = 64;
	localparam int RANDOM_CHARS = 340;

	typedef logic [7:0] octet_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [CHAR_W-1:0]     char_code;
	logic                  end_of_text;
	logic                  empty;
	logic                  pop;
	logic [KIND_W-1:0]     kind;
	logic [ADDR_W-1:0]     byte_address;
	logic [PAGE_NUM_W-1:0] page_number;
	logic [PAGE_OFF_W-1:0] page_offset;
	logic [BYTE_W-1:0]     byte_value;
	logic [ERR_W-1:0]      error_code;
	logic                  last_of_run;

	int mismatches;
	int outstanding;
	int cycle_cnt = 0;
	int fed = 0;
	int hold_at = 1 << 30;
	bit held = 1'b0;

	// hex text to feed: bit 8 is end_of_text, bits 7:0 the character
	logic [8:0] text_q[$];
	octet_t     body_q[$];
	octet_t     rsum;

	intel_hex_record_parser_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.byte_address(byte_address),
		.page_number (page_number),
		.page_offset (page_offset),
		.byte_value  (byte_value),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	ihex_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.byte_address(byte_address),
		.page_number (page_number),
		.page_offset (page_offset),
		.byte_value  (byte_value),
		.error_code  (error_code),
		.last_of_run (last_of_run),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("intel_hex_record_parser_unit verification failed");
			$finish;
		end
	end

	function automatic void put_char(input octet_t c);
		text_q.insert(text_q.size(), {1'b0, c});
	endfunction

	// hex digit in either case
	function automatic octet_t hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_0 + 8'(n);
		return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
	endfunction

	function automatic void put_byte(input octet_t b);
		put_char(hex_char(b[7:4]));
		put_char(hex_char(b[3:0]));
		rsum = 8'(rsum + b);
	endfunction

	function automatic octet_t blank_char();
		octet_t c;
		c = 8'($urandom_range(8, 13));
		return (c == 8'd8) ? CH_SPACE : c;
	endfunction

	function automatic void fill_body(input int n);
		body_q.delete();
		repeat (n) body_q.insert(body_q.size(), 8'($urandom));
	endfunction

	// Whole record with body_q as payload
	function automatic void put_record(input octet_t len, input logic [15:0] addr,
			input octet_t rtype, input bit bad_sum);
		octet_t csum;
		put_char(CH_COLON);
		rsum = '0;
		put_byte(len);
		put_byte(addr[15:8]);
		put_byte(addr[7:0]);
		put_byte(rtype);
		foreach (body_q[i]) put_byte(body_q[i]);
		csum = 8'(8'd0 - rsum);
		if (bad_sum) csum = 8'(csum + $urandom_range(1, 255));
		put_byte(csum);
	endfunction

	task automatic send_char(input logic [8:0] ch, input bit quiet);
		while (!quiet && $urandom_range(99) < 7) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		{end_of_text, char_code} = ch;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stalls, one long hold-off, and a calm window
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && fed >= hold_at) begin
				held = 1'b1;
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop = (cycle_cnt >= 600 && cycle_cnt < 900) || $urandom_range(99) >= 7;
		end
	end

	initial begin
		int     dir_len;
		int     start;
		int     stop;
		int     n;
		int     pick;
		octet_t c;

		arst_n = 1'b0;
		push = 1'b0;
		char_code = '0;
		end_of_text = 1'b0;

		// Directed opening: every blank, empty data record, linear base FFFF,
		// data wrapping past the top of memory, start record with length byte
		// ignored, segment base FFFF
		put_char(CH_SPACE);
		put_char(CH_TAB);
		put_char(8'h0A);
		put_char(8'h0B);
		put_char(8'h0C);
		put_char(CH_CR);
		body_q.delete();
		put_record(8'h00, 16'h0000, REC_DATA, 1'b0);
		body_q = '{8'hFF, 8'hFF};
		put_record(BASE_REC_LEN, 16'h0000, REC_LIN, 1'b0);
		body_q = '{8'h00, 8'hFF};
		put_record(8'h02, 16'hFFFF, REC_DATA, 1'b0);
		body_q = '{8'h12, 8'h34, 8'h56, 8'h78};
		put_record(8'hFF, 16'hFFFF, REC_START, 1'b0);
		body_q = '{8'hFF, 8'hFF};
		put_record(BASE_REC_LEN, 16'h0000, REC_SEG, 1'b0);
		dir_len = text_q.size();

		// Random well-formed records, blanks between some of them
		while (text_q.size() < dir_len + RANDOM_CHARS) begin
			if ($urandom_range(99) < 10) put_char(blank_char());
			pick = $urandom_range(99);
			if (pick < 70) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
				fill_body(n);
				put_record(8'(n), 16'($urandom), REC_DATA, 1'b0);
			end else if (pick < 90) begin
				fill_body(2);
				put_record(BASE_REC_LEN, 16'($urandom), (pick < 80) ? REC_LIN : REC_SEG, 1'b0);
			end else begin
				fill_body(4);
				put_record(8'($urandom), 16'($urandom), REC_START, 1'b0);
			end
		end

		// One way of ending the text; end_of_text rides on the final character
		start = text_q.size();
		case ($urandom_range(7))
			0: begin
				body_q.delete();
				put_record(8'h00, 16'($urandom), REC_EOF, 1'b0);
				stop = start + 8;
			end
			1: begin
				// cut inside the data: last byte and truncation together
				n = $urandom_range(1, 8);
				fill_body(n);
				put_record(8'(n), 16'($urandom), REC_DATA, 1'b0);
				stop = start + 10 + 2 * $urandom_range(0, n - 1);
			end
			2: begin
				if ($urandom_range(1)) put_char(blank_char());
				stop = text_q.size() - 1;
			end
			3: begin
				n = $urandom_range(0, 8);
				fill_body(n);
				put_record(8'(n), 16'($urandom), REC_DATA, 1'b1);
				stop = text_q.size() - 1;
			end
			4: begin
				c = 8'($urandom);
				while (c inside {REC_DATA, REC_EOF, REC_SEG, REC_LIN, REC_START}) begin
					c = 8'($urandom);
				end
				fill_body(2);
				put_record(8'h02, 16'($urandom), c, 1'b0);
				stop = start + 8;
			end
			5: begin
				// base record whose length byte is not two
				c = 8'($urandom_range(0, 254));
				if (c >= BASE_REC_LEN) c = 8'(c + 1);
				fill_body(2);
				put_record(c, 16'($urandom), $urandom_range(1) ? REC_SEG : REC_LIN, 1'b0);
				stop = start + 8;
			end
			6: begin
				// non-hex character somewhere inside a record
				n = $urandom_range(0, 6);
				fill_body(n);
				put_record(8'(n), 16'($urandom), REC_DATA, 1'b0);
				stop = start + $urandom_range(1, 10 + 2 * n);
				c = 8'($urandom);
				while (c inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]}) c = 8'($urandom);
				text_q[stop] = {1'b0, c};
			end
			default: begin
				// stray character where a colon is awaited
				c = 8'($urandom);
				while (c inside {CH_COLON, CH_SPACE, [CH_TAB:CH_CR]}) c = 8'($urandom);
				put_char(c);
				stop = text_q.size() - 1;
			end
		endcase
		while (text_q.size() > stop + 1) text_q.delete(text_q.size() - 1);
		text_q[stop][8] = 1'b1;
		// characters after the finish are taken and ignored
		repeat (20) text_q.insert(text_q.size(), 9'($urandom_range(0, 511)));
		hold_at = dir_len + 120;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < text_q.size(); i++) begin
			// let everything drain once after the directed part
			if (i == dir_len) begin
				push = 1'b0;
				while (outstanding != 0) @(negedge clk);
			end
			send_char(text_q[i], i >= dir_len + 220 && i < dir_len + 320);
			fed = i + 1;
		end
		push = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("intel_hex_record_parser_unit verification clean");
		end else begin
			$display("intel_hex_record_parser_unit verification failed");
		end
		$finish;
	end

endmodule
